### sv/lbc_pkg.sv
// Shared types, codes and widths of the LRU block buffer cache.
package lbc_pkg;

    localparam int NUM_SLOTS_DEF = 32;

    localparam int FUNC_W     = 2;
    localparam int DEV_W      = 4;
    localparam int BLK_W      = 32;
    localparam int SLOT_W     = 5;
    localparam int CNT_W      = 8;
    localparam int TAG_W      = DEV_W + BLK_W;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 16;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ACQUIRE   = 2'd0,
        FUNC_RELEASE   = 2'd1,
        FUNC_WRITE     = 2'd2,
        FUNC_DISK_DONE = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_FREE   = 2'd1,
        STAT_UNHELD    = 2'd2,
        STAT_SATURATED = 2'd3
    } t_status;

    // Result word, slot_out in the low bits.
    typedef struct packed {
        t_status           status;
        logic              need_disk_write;
        logic              need_disk_read;
        logic              hit;
        logic [SLOT_W-1:0] slot_out;
    } t_result;

    localparam int RES_W = $bits(t_result);

endpackage

### sv/lru_block_buffer_cache.sv
// Top level of the LRU block buffer cache tag and policy engine.
//
// Usage: one command word enters on the s_axis channel (kind in tuser), one
// result word leaves on the m_axis channel for every command.
//   acquire   - search from most recent for a device and block match, take a
//               reference; on a miss recycle the least recent unreferenced,
//               clean slot and ask for a read.
//   release   - drop a reference; at zero move the slot to the front.
//   write     - mark a slot dirty and ask for a disk write.
//   disk done - mark a slot valid and clean.
// Acquire, and release when the count reaches zero, walk the recency order
// serially, one slot per cycle through a two-stage read pipeline (a move to
// front uses its first stage only). One command is in work at a time and
// tready rises as the result loads, so a new command word is taken only once
// the last one has left the sequencer.
// A finished result holds in the output register while the receiver stalls;
// the next command runs meanwhile and its result waits in the sequencer.
// Reset (synchronous, active low) clears the per-slot written flags, so tags
// and counts read as zero and the order as NUM_SLOTS-1 down to 0 at once.
module lru_block_buffer_cache #(
    parameter int NUM_SLOTS = lbc_pkg::NUM_SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // device[3:0], block_number[35:4], slot[40:36], zero fill
    input  logic [lbc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // func[1:0]
    input  logic [lbc_pkg::FUNC_W-1:0]     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // slot_out[4:0], hit[5], need_disk_read[6], need_disk_write[7],
    // status[9:8], zero fill
    output logic [lbc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import lbc_pkg::*;

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int PW = $clog2(NUM_SLOTS + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_RCHK = 5'b00100,
        S_MTF  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    // Storage: tags, counts and recency order live in memories; a written
    // flag per entry stands in for the reset value until first write.
    logic [TAG_W-1:0] m_tag [NUM_SLOTS];
    logic [CNT_W-1:0] m_cnt [NUM_SLOTS];
    logic [SW-1:0]    m_ord [NUM_SLOTS];

    logic [NUM_SLOTS-1:0] r_tag_wr, r_cnt_wr, r_ord_wr;
    logic [NUM_SLOTS-1:0] r_valid, r_dirty;

    t_state            r_state;
    t_func             r_func;
    logic [DEV_W-1:0]  r_dev;
    logic [BLK_W-1:0]  r_blk;
    logic [SLOT_W-1:0] r_slot;
    logic [SW-1:0]     r_carry;
    logic [PW-1:0]     r_iss_p;

    // read pipeline: stage 1 holds the order entry, stage 2 tag and count
    logic              r_s1_v, r_s1_last;
    logic [SW-1:0]     r_ord_idx, r_ord_q;
    logic              r_ord_wq;
    logic              r_s2_v, r_s2_last;
    logic [SW-1:0]     r_s2_b;
    logic [TAG_W-1:0]  r_tag_q;
    logic              r_tag_wq;
    logic [CNT_W-1:0]  r_cnt_q;
    logic              r_cnt_wq;

    logic [SW-1:0]     r_cand;
    logic              r_cand_v;

    t_result           r_res, r_out;
    logic              r_out_v;

    // input word fields
    logic              acc_in;
    t_func             in_func;
    logic [DEV_W-1:0]  in_dev;
    logic [BLK_W-1:0]  in_blk;
    logic [SLOT_W-1:0] in_slot;
    logic              in_rng;

    logic [SW-1:0]     slot_idx, ord_val, fill_idx, cnt_raddr;
    logic [TAG_W-1:0]  tag_val;
    logic [CNT_W-1:0]  cnt_val;
    logic              s2_match, s2_free, fill_ok, sat;
    logic              scan_hit, scan_miss, mtf_step, mtf_end, issue;
    logic              tag_we, cnt_we, out_load;
    logic [SW-1:0]     cnt_waddr;
    logic [CNT_W-1:0]  cnt_wdata;

    assign acc_in  = s_axis_tvalid && s_axis_tready;
    assign in_func = t_func'(s_axis_tuser);
    assign in_dev  = s_axis_tdata[DEV_W-1:0];
    assign in_blk  = s_axis_tdata[DEV_W+BLK_W-1:DEV_W];
    assign in_slot = s_axis_tdata[TAG_W+SLOT_W-1:TAG_W];
    assign in_rng  = 32'(in_slot) < NUM_SLOTS;

    assign slot_idx = SW'(r_slot);

    // unwritten entries read as their reset values
    assign ord_val = r_ord_wq ? r_ord_q : (SW'(NUM_SLOTS - 1) - r_ord_idx);
    assign tag_val = r_tag_wq ? r_tag_q : '0;
    assign cnt_val = r_cnt_wq ? r_cnt_q : '0;

    // stage 2 compare: first match wins, last free slot seen is the LRU one
    assign s2_match  = r_s2_v && (tag_val == {r_dev, r_blk});
    assign s2_free   = r_s2_v && (cnt_val == '0) && !r_dirty[r_s2_b];
    assign fill_idx  = s2_free ? r_s2_b : r_cand;
    assign fill_ok   = s2_free || r_cand_v;
    assign sat       = (cnt_val == COUNT_MAX);
    assign scan_hit  = (r_state == S_SCAN) && s2_match;
    assign scan_miss = (r_state == S_SCAN) && !s2_match && r_s2_v && r_s2_last;

    // move to front: shift entries down one by one until the slot is met
    assign mtf_step = (r_state == S_MTF) && r_s1_v;
    assign mtf_end  = mtf_step && ((ord_val == slot_idx) || r_s1_last);

    assign issue = ((r_state == S_SCAN) || (r_state == S_MTF))
                   && (r_iss_p < PW'(NUM_SLOTS))
                   && !(scan_hit || scan_miss || mtf_end);

    assign cnt_raddr = (r_state == S_SCAN) ? ord_val : SW'(in_slot);
    assign tag_we    = scan_miss && fill_ok;
    assign out_load  = (r_state == S_DONE) && (!r_out_v || m_axis_tready);

    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = r_s2_b;
        cnt_wdata = cnt_val + CNT_W'(1);
        if (scan_hit && !sat) begin
            cnt_we = 1'b1;
        end else if (tag_we) begin
            cnt_we    = 1'b1;
            cnt_waddr = fill_idx;
            cnt_wdata = CNT_W'(1);
        end else if ((r_state == S_RCHK) && (cnt_val != '0)) begin
            cnt_we    = 1'b1;
            cnt_waddr = slot_idx;
            cnt_wdata = cnt_val - CNT_W'(1);
        end
    end

    // memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (mtf_step) begin
            m_ord[r_ord_idx] <= r_carry;
        end
        if (issue) begin
            r_ord_q   <= m_ord[r_iss_p[SW-1:0]];
            r_ord_wq  <= r_ord_wr[r_iss_p[SW-1:0]];
            r_ord_idx <= r_iss_p[SW-1:0];
            r_s1_last <= (r_iss_p == PW'(NUM_SLOTS - 1));
        end
        if (tag_we) begin
            m_tag[fill_idx] <= {r_dev, r_blk};
        end
        r_tag_q  <= m_tag[ord_val];
        r_tag_wq <= r_tag_wr[ord_val];
        if (cnt_we) begin
            m_cnt[cnt_waddr] <= cnt_wdata;
        end
        r_cnt_q  <= m_cnt[cnt_raddr];
        r_cnt_wq <= r_cnt_wr[cnt_raddr];
        r_s2_b    <= ord_val;
        r_s2_last <= r_s1_last;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tag_wr <= '0;
            r_cnt_wr <= '0;
            r_ord_wr <= '0;
            r_valid  <= '0;
            r_dirty  <= '0;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_cand_v <= 1'b0;
            r_iss_p  <= '0;
            r_out_v  <= 1'b0;
        end else begin
            if (tag_we) begin
                r_tag_wr[fill_idx] <= 1'b1;
            end
            if (cnt_we) begin
                r_cnt_wr[cnt_waddr] <= 1'b1;
            end
            if (mtf_step) begin
                r_ord_wr[r_ord_idx] <= 1'b1;
            end
            if (issue) begin
                r_iss_p <= r_iss_p + PW'(1);
            end

            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (acc_in) begin
                        r_func   <= in_func;
                        r_dev    <= in_dev;
                        r_blk    <= in_blk;
                        r_slot   <= in_slot;
                        r_carry  <= SW'(in_slot);
                        r_iss_p  <= '0;
                        r_s1_v   <= 1'b0;
                        r_s2_v   <= 1'b0;
                        r_cand_v <= 1'b0;
                        // out-of-range slot drops a release, write or disk done as unheld
                        r_res    <= '{status: ((in_func != FUNC_ACQUIRE) && !in_rng)
                                              ? STAT_UNHELD : STAT_OK,
                                      need_disk_write: (in_func == FUNC_WRITE) && in_rng,
                                      need_disk_read: 1'b0, hit: 1'b0,
                                      slot_out: in_slot};
                        if (in_func == FUNC_ACQUIRE) begin
                            r_state <= S_SCAN;
                        end else if (!in_rng) begin
                            r_state <= S_DONE;
                        end else begin
                            case (in_func)
                                FUNC_RELEASE: begin
                                    r_state <= S_RCHK;
                                end
                                FUNC_WRITE: begin
                                    r_dirty[SW'(in_slot)] <= 1'b1;
                                    r_state               <= S_DONE;
                                end
                                default: begin
                                    r_valid[SW'(in_slot)] <= 1'b1;
                                    r_dirty[SW'(in_slot)] <= 1'b0;
                                    r_state               <= S_DONE;
                                end
                            endcase
                        end
                    end
                end
                S_SCAN: begin
                    r_s1_v <= issue;
                    r_s2_v <= r_s1_v;
                    if (s2_free) begin
                        r_cand   <= r_s2_b;
                        r_cand_v <= 1'b1;
                    end
                    if (scan_hit) begin
                        r_res   <= '{status: sat ? STAT_SATURATED : STAT_OK,
                                     need_disk_write: 1'b0,
                                     need_disk_read: !sat && !r_valid[r_s2_b],
                                     hit: 1'b1, slot_out: SLOT_W'(r_s2_b)};
                        r_state <= S_DONE;
                    end else if (scan_miss) begin
                        if (fill_ok) begin
                            r_valid[fill_idx] <= 1'b0;
                            r_dirty[fill_idx] <= 1'b0;
                        end
                        r_res   <= '{status: fill_ok ? STAT_OK : STAT_NO_FREE,
                                     need_disk_write: 1'b0,
                                     need_disk_read: fill_ok, hit: 1'b0,
                                     slot_out: fill_ok ? SLOT_W'(fill_idx)
                                                       : SLOT_W'(0)};
                        r_state <= S_DONE;
                    end
                end
                S_RCHK: begin
                    if (cnt_val == '0) begin
                        r_res.status <= STAT_UNHELD;
                        r_state      <= S_DONE;
                    end else if (cnt_val == CNT_W'(1)) begin
                        // count drops to zero: walk the order from the front
                        r_state <= S_MTF;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_MTF: begin
                    r_s1_v <= issue;
                    if (mtf_step) begin
                        r_carry <= ord_val;
                    end
                    if (mtf_end) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {(OUT_DATA_W - RES_W)'(0), r_out};

    // an accepted command always takes the sequencer out of idle in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_in |=> !s_axis_tready)
        else $error("command accepted but sequencer still idle");

    // a full cache returns slot 0 with no hit and no read request
    a_no_free_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && (r_out.status == STAT_NO_FREE)) |->
        (!r_out.hit && !r_out.need_disk_read && (r_out.slot_out == '0)))
        else $error("no-free result carries slot data");

    // a write request never comes with a hit or a read request
    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.need_disk_write) |->
        (!r_out.hit && !r_out.need_disk_read && (r_out.status == STAT_OK)))
        else $error("write result mixed with acquire fields");

    // the order memory is only rewritten during a move to front
    a_order_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mtf_step |-> ((r_func == FUNC_RELEASE) && !scan_hit && !tag_we))
        else $error("recency order written outside a release");

endmodule

### bench/tb_lru_block_buffer_cache.sv
// Self-checking testbench of the LRU block buffer cache tag and policy engine.
module tb_lru_block_buffer_cache;

    import lbc_pkg::*;

    localparam int NSLOT        = NUM_SLOTS_DEF;
    localparam int TAG_POOL     = 48;     // more tags than slots, so misses recycle
    localparam int RANDOM_ITEMS = 760;
    localparam int IDLE_LIMIT   = 4000;   // cycles with no word moving on either side
    localparam int DRAIN_CYCLES = 2 * NSLOT + 16;
    localparam int FILL_W       = IN_DATA_W - DEV_W - BLK_W - SLOT_W;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // device[3:0], block_number[35:4], slot[40:36], zero fill
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // func[1:0]
    logic [FUNC_W-1:0]     s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // slot_out[4:0], hit[5], need_disk_read[6], need_disk_write[7], status[9:8]
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    lru_block_buffer_cache #(
        .NUM_SLOTS(NSLOT)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Shadow copy of the cache tags, counts and marks, plus the recency order
    // (index 0 is the most recently released slot).
    logic [DEV_W-1:0] cache_dev   [NSLOT];
    logic [BLK_W-1:0] cache_blk   [NSLOT];
    logic [CNT_W-1:0] cache_refs  [NSLOT];
    bit               cache_valid [NSLOT];
    bit               cache_dirty [NSLOT];
    int               lru_order   [NSLOT];

    // Tags that the random traffic draws from.
    logic [DEV_W-1:0] pool_dev [TAG_POOL];
    logic [BLK_W-1:0] pool_blk [TAG_POOL];

    t_result pending_results[$];   // predicted result words, oldest first
    int      mismatch_count = 0;
    int      results_taken  = 0;
    int      last_slot;            // slot of the most recent prediction
    bit      tx_gaps;              // sender inserts idle gaps
    bit      rx_gaps;              // receiver inserts stalls
    int      rx_hold_cycles = 0;   // long receiver hold-off, counted by the receiver
    int      idle_cycles    = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Mostly zero or short, sometimes medium, rarely long.
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Apply one command to the shadow cache and return the result word it
    // must produce.
    function automatic t_result predict_cache_op(t_func op, logic [DEV_W-1:0] dev,
                                                 logic [BLK_W-1:0] blk,
                                                 logic [SLOT_W-1:0] slot);
        t_result r;
        bit      found;
        int      s;
        int      p;
        r = '0;
        r.status = STAT_OK;
        found = 1'b0;
        if (op == FUNC_ACQUIRE) begin
            // Search for a tag match from the most recent slot; a match takes
            // a reference unless the count is pinned at its maximum.
            for (p = 0; p < NSLOT && !found; p++) begin
                s = lru_order[p];
                if (cache_dev[s] == dev && cache_blk[s] == blk) begin
                    found = 1'b1;
                    r.slot_out = SLOT_W'(s);
                    r.hit = 1'b1;
                    if (cache_refs[s] == COUNT_MAX) begin
                        r.status = STAT_SATURATED;
                    end else begin
                        cache_refs[s]++;
                        r.need_disk_read = !cache_valid[s];
                    end
                end
            end
            // Miss: recycle the least recent slot that is free and clean.
            for (p = NSLOT - 1; p >= 0 && !found; p--) begin
                s = lru_order[p];
                if (cache_refs[s] == 0 && !cache_dirty[s]) begin
                    found = 1'b1;
                    r.slot_out = SLOT_W'(s);
                    cache_dev[s]   = dev;
                    cache_blk[s]   = blk;
                    cache_valid[s] = 1'b0;
                    cache_dirty[s] = 1'b0;
                    cache_refs[s]  = CNT_W'(1);
                    r.need_disk_read = 1'b1;
                end
            end
            if (!found) r.status = STAT_NO_FREE;
        end else begin
            r.slot_out = slot;
            s = int'(slot);
            if (s >= NSLOT) begin
                r.status = STAT_UNHELD;
            end else if (op == FUNC_RELEASE) begin
                if (cache_refs[s] == 0) begin
                    r.status = STAT_UNHELD;
                end else begin
                    cache_refs[s]--;
                    if (cache_refs[s] == 0) begin
                        // Move to the front of the recency order.
                        p = 0;
                        while (lru_order[p] != s) p++;
                        for (; p > 0; p--) lru_order[p] = lru_order[p-1];
                        lru_order[0] = s;
                    end
                end
            end else if (op == FUNC_WRITE) begin
                cache_dirty[s] = 1'b1;
                r.need_disk_write = 1'b1;
            end else begin
                cache_valid[s] = 1'b1;
                cache_dirty[s] = 1'b0;
            end
        end
        return r;
    endfunction

    // Random slot that is held (want_dirty 0) or dirty (want_dirty 1); -1 if none.
    function automatic int pick_slot(bit want_dirty);
        int cand[$];
        for (int s = 0; s < NSLOT; s++) begin
            if (want_dirty ? cache_dirty[s] : (cache_refs[s] != 0)) cand.push_back(s);
        end
        if (cand.size() == 0) return -1;
        return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    task automatic report_mismatch(string what, int seen, int want);
        $display("ERROR t=%0t result #%0d %s: got %0h expected %0h",
                 $time, results_taken, what, seen, want);
        mismatch_count++;
    endtask

    // Offer one command word, hold it until accepted, then record its
    // prediction. Valid stays high into the next word when no gap is drawn.
    task automatic send_word(t_func op, logic [DEV_W-1:0] dev, logic [BLK_W-1:0] blk,
                             logic [SLOT_W-1:0] slot);
        t_result want;
        int      gap;
        @(negedge i_clk);
        s_axis_tdata  = {{FILL_W{1'b0}}, slot, blk, dev};
        s_axis_tuser  = op;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        want = predict_cache_op(op, dev, blk, slot);
        last_slot = int'(want.slot_out);
        pending_results.push_back(want);
        gap = tx_gaps ? idle_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Drop every reference and finish every pending disk write, so the next
    // test starts from a quiet cache.
    task automatic settle_cache();
        for (int s = 0; s < NSLOT; s++) begin
            while (cache_refs[s] != 0) send_word(FUNC_RELEASE, '0, '0, SLOT_W'(s));
            if (cache_dirty[s]) send_word(FUNC_DISK_DONE, '0, '0, SLOT_W'(s));
        end
    endtask

    // Zero tags after reset: device 0 block 0 hits the most recent slot and
    // still needs a read until its disk transfer completes.
    task automatic test_reset_tags();
        send_word(FUNC_ACQUIRE, 4'h0, 32'h0, 5'd0);
        send_word(FUNC_ACQUIRE, 4'h0, 32'h0, 5'd0);
        send_word(FUNC_DISK_DONE, 4'h0, 32'h0, 5'd31);
        send_word(FUNC_ACQUIRE, 4'h0, 32'h0, 5'd0);
        repeat (3) send_word(FUNC_RELEASE, 4'h0, 32'h0, 5'd31);
        send_word(FUNC_RELEASE, 4'h0, 32'h0, 5'd31);   // unheld now
    endtask

    // Every operation with field extremes, write on an unheld slot, a hit on
    // a dirty slot, release of an unheld slot.
    task automatic test_ops_extremes();
        send_word(FUNC_ACQUIRE, 4'hF, 32'hFFFF_FFFF, 5'd31);
        send_word(FUNC_ACQUIRE, 4'hF, 32'h0000_0000, 5'd0);
        send_word(FUNC_ACQUIRE, 4'h0, 32'hFFFF_FFFF, 5'd0);
        send_word(FUNC_ACQUIRE, 4'h5, 32'h5A5A_5A5A, 5'd21);
        send_word(FUNC_ACQUIRE, 4'hA, 32'hA5A5_A5A5, 5'd10);
        send_word(FUNC_ACQUIRE, 4'hF, 32'hFFFF_FFFF, 5'd0);
        send_word(FUNC_WRITE, 4'hF, 32'hFFFF_FFFF, 5'd0);
        send_word(FUNC_WRITE, 4'h0, 32'h0, 5'd31);
        send_word(FUNC_RELEASE, 4'h0, 32'h0, 5'd0);
        send_word(FUNC_RELEASE, 4'h0, 32'h0, 5'd0);
        send_word(FUNC_ACQUIRE, 4'h0, 32'h0, 5'd31);
        send_word(FUNC_RELEASE, 4'h0, 32'h0, 5'd31);
        send_word(FUNC_DISK_DONE, 4'hF, 32'hFFFF_FFFF, 5'd0);
        send_word(FUNC_DISK_DONE, 4'h0, 32'h0, 5'd31);
        send_word(FUNC_RELEASE, 4'h0, 32'h0, 5'd0);
        send_word(FUNC_DISK_DONE, 4'h0, 32'h0, 5'd4);
        send_word(FUNC_ACQUIRE, 4'hA, 32'hA5A5_A5A5, 5'd31);
        settle_cache();
    endtask

    // Hold every slot, then show that a dirty unreferenced slot still blocks
    // recycling until its disk transfer completes.
    task automatic test_exhaust();
        for (int n = 0; n <= NSLOT; n++) begin
            send_word(FUNC_ACQUIRE, 4'h9, 32'hC000_0000 + n, 5'd0);
        end
        send_word(FUNC_WRITE, 4'h0, 32'h0, 5'd5);
        send_word(FUNC_RELEASE, 4'h0, 32'h0, 5'd5);
        send_word(FUNC_ACQUIRE, 4'h9, 32'hC000_1000, 5'd0);
        send_word(FUNC_DISK_DONE, 4'h0, 32'h0, 5'd5);
        send_word(FUNC_ACQUIRE, 4'h9, 32'hC000_1001, 5'd0);
        settle_cache();
    endtask

    // Drive one slot's count to its ceiling and past it, then back to zero.
    // The first stretch runs with no idling on either side.
    task automatic test_saturate();
        int target;
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        send_word(FUNC_ACQUIRE, 4'hC, 32'h0BAD_F00D, 5'd0);
        target = last_slot;
        send_word(FUNC_DISK_DONE, 4'h0, 32'h0, SLOT_W'(target));
        repeat (int'(COUNT_MAX) - 1) send_word(FUNC_ACQUIRE, 4'hC, 32'h0BAD_F00D, 5'd0);
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        repeat (2) send_word(FUNC_ACQUIRE, 4'hC, 32'h0BAD_F00D, 5'd0);
        send_word(FUNC_WRITE, 4'h0, 32'h0, SLOT_W'(target));
        send_word(FUNC_DISK_DONE, 4'h0, 32'h0, SLOT_W'(target));
        settle_cache();
    endtask

    // Hold off the receiver for a long stretch while words keep coming, so
    // the result path fills and the block drops tready on its input.
    task automatic test_backpressure();
        int k;
        tx_gaps = 1'b0;
        rx_hold_cycles = 250;
        for (int n = 0; n < 20; n++) begin
            k = $urandom_range(0, TAG_POOL - 1);
            if (n % 3 == 2 && pick_slot(1'b0) >= 0) begin
                send_word(FUNC_RELEASE, '0, '0, SLOT_W'(pick_slot(1'b0)));
            end else begin
                send_word(FUNC_ACQUIRE, pool_dev[k], pool_blk[k], '0);
            end
        end
        tx_gaps = 1'b1;
    endtask

    // Mostly well-formed traffic: acquires from a shared tag pool, releases
    // and writes of held slots, disk completions of dirty slots, with some
    // fully random words mixed in.
    task automatic test_random_traffic();
        int held;
        int roll;
        int k;
        int s;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0) begin
                tx_gaps = ($urandom_range(0, 3) != 0);
                rx_gaps = ($urandom_range(0, 3) != 0);
            end
            held = 0;
            for (int i = 0; i < NSLOT; i++) if (cache_refs[i] != 0) held++;
            roll = $urandom_range(0, 99);
            if (held > 26 && roll >= 8) roll = 60;   // keep some slots free
            k = $urandom_range(0, TAG_POOL - 1);
            if (roll < 8) begin
                send_word(t_func'($urandom_range(0, 3)), DEV_W'($urandom_range(0, 15)),
                          $urandom, SLOT_W'($urandom_range(0, 31)));
            end else if (roll < 48) begin
                send_word(FUNC_ACQUIRE, pool_dev[k], pool_blk[k],
                          SLOT_W'($urandom_range(0, 31)));
            end else if (roll < 78) begin
                s = pick_slot(1'b0);
                if (s < 0) send_word(FUNC_ACQUIRE, pool_dev[k], pool_blk[k], '0);
                else       send_word(FUNC_RELEASE, '0, '0, SLOT_W'(s));
            end else if (roll < 88) begin
                s = pick_slot(1'b0);
                if (s < 0) s = $urandom_range(0, NSLOT - 1);
                send_word(FUNC_WRITE, '0, '0, SLOT_W'(s));
            end else begin
                s = pick_slot(1'b1);
                if (s < 0) s = $urandom_range(0, NSLOT - 1);
                send_word(FUNC_DISK_DONE, '0, '0, SLOT_W'(s));
            end
        end
    endtask

    // Receiver: drive tready at the falling edge. A long hold-off takes
    // precedence, then any stall in progress, then a fresh random draw.
    initial begin : result_sink
        int stall;
        stall = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                m_axis_tready = 1'b0;
                rx_hold_cycles--;
            end else if (stall > 0) begin
                m_axis_tready = 1'b0;
                stall--;
            end else begin
                m_axis_tready = 1'b1;
                if (rx_gaps && $urandom_range(0, 3) == 0) stall = idle_gap();
            end
        end
    end

    // Compare every accepted result word with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[RES_W-1:0]);
            results_taken++;
            if (pending_results.size() == 0) begin
                report_mismatch("word with nothing expected", int'(m_axis_tdata), 0);
            end else begin
                want = pending_results.pop_front();
                if (got.slot_out != want.slot_out)
                    report_mismatch("slot_out", got.slot_out, want.slot_out);
                if (got.hit != want.hit)
                    report_mismatch("hit", got.hit, want.hit);
                if (got.need_disk_read != want.need_disk_read)
                    report_mismatch("need_disk_read", got.need_disk_read,
                                    want.need_disk_read);
                if (got.need_disk_write != want.need_disk_write)
                    report_mismatch("need_disk_write", got.need_disk_write,
                                    want.need_disk_write);
                if (got.status != want.status)
                    report_mismatch("status", got.status, want.status);
                if (m_axis_tdata[OUT_DATA_W-1:RES_W] != '0)
                    report_mismatch("zero fill", m_axis_tdata[OUT_DATA_W-1:RES_W], 0);
            end
        end
    end

    // Watchdog: end the run when no word moves on either side for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : test_sequence
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_ACQUIRE;
        tx_gaps       = 1'b1;
        rx_gaps       = 1'b1;
        last_slot     = 0;
        for (int s = 0; s < NSLOT; s++) begin
            cache_dev[s]   = '0;
            cache_blk[s]   = '0;
            cache_refs[s]  = '0;
            cache_valid[s] = 1'b0;
            cache_dirty[s] = 1'b0;
            lru_order[s]   = NSLOT - 1 - s;
        end
        // Few devices and a mix of random and extreme blocks, so the same
        // tags come back often enough to hit.
        for (int k = 0; k < TAG_POOL; k++) begin
            pool_dev[k] = DEV_W'($urandom_range(0, 3) == 0 ? $urandom_range(0, 15)
                                                            : $urandom_range(0, 2));
            pool_blk[k] = (k < 4) ? ((k % 2 == 0) ? 32'h0 : 32'hFFFF_FFFF) : $urandom;
        end
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_tags();
        test_ops_extremes();
        test_exhaust();
        test_saturate();
        test_backpressure();
        test_random_traffic();

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        // Wait out every outstanding result, then watch for strays.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
